### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, held off during reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, held off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fdft_pkg.sv
`timescale 1ns / 1ps

package fdft_pkg;

    // Table geometry and timing
    localparam int NUM_CHANNELS = 32;
    localparam int TICK_MS      = 100;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_W       = 8;
    localparam int MS_W         = 16;
    localparam int TICK_W       = 10;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // ms / TICK_MS as a multiply by a rounded-up reciprocal; exact for 16-bit ms
    // while TICK_MS stays below 1024
    localparam int DIV_SHIFT = 26;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = MS_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + TICK_MS - 1) / TICK_MS);

    // Operation codes
    typedef enum logic [2:0] {
        OP_CONFIGURE    = 3'd0,
        OP_CHANGE_TIMES = 3'd1,
        OP_START        = 3'd2,
        OP_STOP         = 3'd3,
        OP_SET_FILTERED = 3'd4,
        OP_SET_SAMPLE   = 3'd5,
        OP_TICK         = 3'd6,
        OP_QUERY        = 3'd7
    } op_t;

    // Filter / sample state codes
    localparam logic [1:0] FLT_NORMAL = 2'd0;
    localparam logic [1:0] FLT_FAULT  = 2'd1;
    localparam logic [1:0] FLT_N2F    = 2'd2;
    localparam logic [1:0] FLT_F2N    = 2'd3;
    localparam logic [1:0] QRY_BAD_ID = 2'd2;

    // Control sequencer
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MODIFY,
        FSM_SWEEP
    } fsm_t;

    // One table entry; all-zero is the reset value
    typedef struct packed {
        logic              enabled;
        logic [1:0]        filt;
        logic [1:0]        samp;
        logic [2:0]        sev;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] mature;
        logic [TICK_W-1:0] recover;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    // Result item fields
    typedef struct packed {
        logic [2:0] level;
        logic [1:0] sample;
        logic [1:0] transit;
        logic [1:0] filtered;
        logic       id_valid;
    } res_t;

    // Milliseconds to ticks, saturating
    function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        prod = PROD_W'(ms) * PROD_W'(DIV_RECIP);
        quot = prod[PROD_W-1:DIV_SHIFT];
        if (quot > QUOT_W'(TICK_MAX)) begin
            return TICK_MAX;
        end
        return quot[TICK_W-1:0];
    endfunction

    // One debounce step of an enabled channel
    function automatic ent_t tick_entry(input ent_t e);
        ent_t              r;
        logic [TICK_W-1:0] t;
        r = e;
        t = (e.tick < TICK_MAX) ? e.tick + 1'b1 : e.tick;
        case (e.filt)
            FLT_NORMAL: begin
                if (e.samp == FLT_FAULT) begin
                    r.filt = FLT_N2F;
                    r.tick = '0;
                end
            end
            FLT_N2F: begin
                if (e.samp == FLT_FAULT) begin
                    if (t >= e.mature) begin
                        r.filt = FLT_FAULT;
                        r.tick = '0;
                    end else begin
                        r.tick = t;
                    end
                end else if (e.samp == FLT_NORMAL) begin
                    r.filt = FLT_NORMAL;
                    r.tick = '0;
                end
            end
            FLT_FAULT: begin
                if (e.samp == FLT_NORMAL) begin
                    r.filt = FLT_F2N;
                    r.tick = '0;
                end
            end
            default: begin
                if (e.samp == FLT_NORMAL) begin
                    if (t >= e.recover) begin
                        r.filt = FLT_NORMAL;
                        r.tick = '0;
                    end else begin
                        r.tick = t;
                    end
                end else if (e.samp == FLT_FAULT) begin
                    r.filt = FLT_FAULT;
                    r.tick = '0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

### design/fault_debounce_filter_table.sv
`timescale 1ns / 1ps
// Fault debounce filter table. All channel state (enable, sample, four-state
// filter, tick timer, maturation/recovery thresholds, level) sits in one
// NUM_CHANNELS-entry synchronous RAM with one read and one write port; a valid
// bit per entry makes never-written entries read as the all-zero reset value,
// so no clearing pass is needed. A channel operation (configure, change times,
// start, stop, set filtered, set sample, query) issues the RAM read on the input
// transfer; the entry is then modified and written back, and the result loaded,
// once the output register is free. A tick sweeps the whole table through the
// RAM port pair. One result transfer follows every input transfer; a new input
// is taken while the previous result still waits in the output register.
`include "assert_macros.svh"

module fault_debounce_filter_table (
    input  logic        aclk,
    input  logic        aresetn,
    // Operation input
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel[7:0], fault_level[10:8], state_value[12:11], mature_ms[28:13],
    // recover_ms[44:29], zero fill [47:45]
    input  logic [47:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]  s_tuser,
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // id_valid[0], filtered_state[2:1], transit_state[4:3], sample_state[6:5],
    // level_out[9:7], zero fill [15:10]
    output logic [15:0] m_tdata
);

    localparam logic [fdft_pkg::IDX_W-1:0] LAST_IDX =
        fdft_pkg::IDX_W'(fdft_pkg::NUM_CHANNELS - 1);

    // Sequencer
    fdft_pkg::fsm_t state_reg, state_next;
    logic [fdft_pkg::IDX_W-1:0] idx_reg, idx_next;

    // Captured operation
    fdft_pkg::op_t              op_reg;
    logic [fdft_pkg::CHAN_W-1:0] chan_reg;
    logic [2:0]                 lvl_reg;
    logic [1:0]                 sv_reg;
    logic [fdft_pkg::MS_W-1:0]  mature_reg;
    logic [fdft_pkg::MS_W-1:0]  recover_reg;
    logic                       id_ok_reg;

    // Channel RAM
    logic [fdft_pkg::ENT_W-1:0] mem [fdft_pkg::NUM_CHANNELS];
    logic [fdft_pkg::NUM_CHANNELS-1:0] ent_valid_reg;
    logic [fdft_pkg::ENT_W-1:0] rd_raw_reg;
    logic                       rd_hit_reg;
    logic                       rd_en;
    logic [fdft_pkg::IDX_W-1:0] rd_addr;
    logic                       wr_en;
    logic [fdft_pkg::IDX_W-1:0] wr_addr;
    fdft_pkg::ent_t             wr_data;
    fdft_pkg::ent_t             rd_ent;

    // Result register
    logic                       m_tvalid_reg;
    logic [15:0]                m_tdata_reg;
    logic                       load_out;
    fdft_pkg::res_t             res;
    logic                       out_free;

    logic                       s_accept;
    logic                       s_id_ok;
    fdft_pkg::ent_t             mod_ent;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_id_ok  = {1'b0, s_tdata[7:0]} < 9'(fdft_pkg::NUM_CHANNELS);
    assign rd_ent   = rd_hit_reg ? fdft_pkg::ent_t'(rd_raw_reg) : '0;

    // Capture the operation on transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg      <= fdft_pkg::op_t'(s_tuser);
            chan_reg    <= s_tdata[7:0];
            lvl_reg     <= s_tdata[10:8];
            sv_reg      <= s_tdata[12:11];
            mature_reg  <= s_tdata[28:13];
            recover_reg <= s_tdata[44:29];
            id_ok_reg   <= s_id_ok;
        end
    end

    // RAM read port, registered output
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_raw_reg <= mem[rd_addr];
            rd_hit_reg <= ent_valid_reg[rd_addr];
        end
    end

    // RAM write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Entry valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (wr_en) begin
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Single-channel modify
    always_comb begin
        mod_ent = rd_ent;
        case (op_reg)
            fdft_pkg::OP_CONFIGURE: begin
                mod_ent.sev     = lvl_reg;
                mod_ent.filt    = sv_reg;
                mod_ent.samp    = sv_reg;
                mod_ent.mature  = fdft_pkg::ms_to_ticks(mature_reg);
                mod_ent.recover = fdft_pkg::ms_to_ticks(recover_reg);
                mod_ent.tick    = '0;
            end
            fdft_pkg::OP_CHANGE_TIMES: begin
                mod_ent.mature  = fdft_pkg::ms_to_ticks(mature_reg);
                mod_ent.recover = fdft_pkg::ms_to_ticks(recover_reg);
            end
            fdft_pkg::OP_START:       mod_ent.enabled = 1'b1;
            fdft_pkg::OP_STOP:        mod_ent.enabled = 1'b0;
            fdft_pkg::OP_SET_FILTERED: mod_ent.filt   = sv_reg;
            fdft_pkg::OP_SET_SAMPLE:  mod_ent.samp    = sv_reg;
            default: ;
        endcase
    end

    // Result word
    always_comb begin
        res          = '0;
        res.id_valid = id_ok_reg;
        if (op_reg == fdft_pkg::OP_TICK) begin
            res.id_valid = 1'b1;
        end else if (op_reg == fdft_pkg::OP_QUERY) begin
            if (id_ok_reg) begin
                case (rd_ent.filt)
                    fdft_pkg::FLT_N2F: res.filtered = fdft_pkg::FLT_NORMAL;
                    fdft_pkg::FLT_F2N: res.filtered = fdft_pkg::FLT_FAULT;
                    default:           res.filtered = rd_ent.filt;
                endcase
                res.transit = rd_ent.filt;
                res.sample  = rd_ent.samp;
                res.level   = rd_ent.sev;
            end else begin
                res.filtered = fdft_pkg::QRY_BAD_ID;
            end
        end
    end

    // Sequencer next state and RAM control
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = chan_reg[fdft_pkg::IDX_W-1:0];
        wr_data    = mod_ent;
        load_out   = 1'b0;
        case (state_reg)
            fdft_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    rd_en = 1'b1;
                    if (fdft_pkg::op_t'(s_tuser) == fdft_pkg::OP_TICK) begin
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = fdft_pkg::FSM_SWEEP;
                    end else begin
                        rd_addr    = s_tdata[fdft_pkg::IDX_W-1:0];
                        state_next = fdft_pkg::FSM_MODIFY;
                    end
                end
            end
            fdft_pkg::FSM_MODIFY: begin
                if (out_free) begin
                    wr_en      = id_ok_reg && (op_reg != fdft_pkg::OP_QUERY);
                    load_out   = 1'b1;
                    state_next = fdft_pkg::FSM_IDLE;
                end
            end
            fdft_pkg::FSM_SWEEP: begin
                // write back entry idx while reading idx + 1
                wr_addr = idx_reg;
                wr_data = rd_ent.enabled ? fdft_pkg::tick_entry(rd_ent) : rd_ent;
                if (idx_reg != LAST_IDX) begin
                    wr_en    = 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    wr_en      = 1'b1;
                    load_out   = 1'b1;
                    state_next = fdft_pkg::FSM_IDLE;
                end
            end
            default: state_next = fdft_pkg::FSM_IDLE;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fdft_pkg::FSM_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {6'd0, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `ASSERT_SAME(a_no_rw_collide, rd_en && wr_en, rd_addr != wr_addr,
                 "RAM read and write hit the same entry")
    `ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg != fdft_pkg::FSM_IDLE,
                 "transfer accepted but sequencer stayed idle")
    `ASSERT_SAME(a_load_slot, load_out, !m_tvalid_reg || m_tready,
                 "result loaded over an untaken result")
    `ASSERT_NEXT(a_sweep_runs, state_reg == fdft_pkg::FSM_SWEEP && idx_reg != LAST_IDX,
                 state_reg == fdft_pkg::FSM_SWEEP, "tick sweep ended early")

endmodule
